/* rtl/elcdf_pkg.sv */
// Shared types, constants and codes for the emitter light CDF builder.
`timescale 1ns / 1ps
`default_nettype none

package elcdf_pkg;

    localparam int MAX_LIGHTS_DEFAULT    = 1024;
    localparam int MAX_TRIANGLES_DEFAULT = 65536;

    localparam logic [15:0] LUM_RED   = 16'd13933;
    localparam logic [15:0] LUM_GREEN = 16'd46871;
    localparam logic [15:0] LUM_BLUE  = 16'd4732;

    localparam logic [5:0]  EMIT_THRESHOLD = 6'd16;
    localparam logic [47:0] TOTAL_MAX      = 48'hFFFF_FFFF_FFFF;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_PUSH  = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [1:0] MUL_RED   = 2'd0;
    localparam logic [1:0] MUL_GREEN = 2'd1;
    localparam logic [1:0] MUL_BLUE  = 2'd2;
    localparam logic [1:0] MUL_AREA  = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] emissive_red;
        logic [15:0] emissive_green;
        logic [15:0] emissive_blue;
        logic [31:0] tri_area;
        logic [9:0]  read_slot;
    } in_item_t;

    typedef struct packed {
        logic        accepted;
        logic        overflow;
        logic [10:0] light_total_count;
        logic [15:0] light_triangle;
        logic [16:0] cdf_value;
        logic [47:0] total_weight;
        logic        read_valid;
    } out_item_t;

    typedef struct packed {
        logic       capture;
        logic       res_clear;
        logic       clear;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       acc_load;
        logic       acc_add;
        logic       push_commit;
        logic       mem_rd;
        logic       div_init;
        logic       div_step;
        logic       load_out;
    } cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       lum_mode;
        logic       div_needed;
        logic       div_last;
    } status_t;

endpackage

`default_nettype wire

/* rtl/emitter_light_cdf_builder_top.sv */
// Top level of the emitter light CDF builder: controller, datapath and checks.
// Clear and unused actions go straight to the result; a push commits directly, or in luminance
// mode after four passes through the shared 16x32 multiplier; a read fetches the slot and then
// runs the 17-step restoring divider when the slot is valid and the running total is nonzero.
// One item is in work at a time; the next is taken once the controller is back in idle after
// its result is registered, so a result held in a stalled output register also holds the input.
// Reset clears counters, running total, mode and handshakes; the slot store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module emitter_light_cdf_builder_top #(
    parameter int MAX_LIGHTS    = elcdf_pkg::MAX_LIGHTS_DEFAULT,
    parameter int MAX_TRIANGLES = elcdf_pkg::MAX_TRIANGLES_DEFAULT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire elcdf_pkg::in_item_t  s_item,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output elcdf_pkg::out_item_t      m_item,
    input  wire logic                 cfg_wr_en,
    input  wire logic                 cfg_wr_data
);
    import elcdf_pkg::*;

    cmd_t    cmd;
    status_t status;

    elcdf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    elcdf_datapath #(
        .MAX_LIGHTS    (MAX_LIGHTS),
        .MAX_TRIANGLES (MAX_TRIANGLES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_item      (s_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status),
        .m_item      (m_item)
    );

    // A result is only loaded when the output register is free.
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid || m_ready))
        else $error("result loaded over a pending transfer");

    // The controller never takes a second item straight after a transfer.
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item taken while one is in work");

    // Only one datapath operation that touches the store or divider at a time.
    a_ops_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.push_commit, cmd.mem_rd, cmd.div_init, cmd.div_step, cmd.clear}))
        else $error("conflicting datapath commands");

    // A normalised value never exceeds one.
    a_cdf_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.read_valid) |-> (m_item.cdf_value <= 17'h10000))
        else $error("normalised value out of range");

    // A push is either stored or dropped, never both.
    a_push_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_item.accepted && m_item.overflow))
        else $error("push both stored and dropped");

endmodule

`default_nettype wire

/* rtl/elcdf_datapath.sv */
// Datapath: item capture, shared multiplier, table store, divider and output register.
`timescale 1ns / 1ps
`default_nettype none

module elcdf_datapath #(
    parameter int MAX_LIGHTS    = 1024,
    parameter int MAX_TRIANGLES = 65536
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire elcdf_pkg::in_item_t  s_item,
    input  wire logic                 cfg_wr_en,
    input  wire logic                 cfg_wr_data,
    input  wire elcdf_pkg::cmd_t      cmd,
    output elcdf_pkg::status_t        status,
    output elcdf_pkg::out_item_t      m_item
);
    import elcdf_pkg::*;

    localparam int ADDR_W = $clog2(MAX_LIGHTS);
    localparam int CNT_W  = $clog2(MAX_LIGHTS + 1);
    localparam int TRI_W  = $clog2(MAX_TRIANGLES + 1);

    in_item_t    item_reg;
    logic        lum_mode_reg;
    logic [TRI_W-1:0] tri_cnt_reg, tri_cnt_next;
    logic [CNT_W-1:0] emit_cnt_reg, emit_cnt_next;
    logic [47:0] total_reg, total_next;

    logic [47:0] prod_reg;
    logic [31:0] acc_reg;
    logic [15:0] mul_a;
    logic [31:0] mul_b;

    logic [15:0] tri_mem [MAX_LIGHTS];
    logic [47:0] cum_mem [MAX_LIGHTS];
    logic [15:0] rd_tri_reg;
    logic [47:0] rd_cum_reg;

    logic [47:0] rem_reg;
    logic [4:0]  div_cnt_reg;
    logic [48:0] rem_shift;
    logic [48:0] rem_diff;
    logic        q_bit;

    logic        res_accepted_reg;
    logic        res_overflow_reg;
    logic        res_valid_reg;
    logic [15:0] res_tri_reg;
    logic [16:0] res_cdf_reg;
    out_item_t   out_reg;

    logic        big_comp;
    logic [5:0]  small_sum;
    logic        emitter;
    logic        saturated;
    logic        full;
    logic        push_store;
    logic        push_over;
    logic [47:0] weight;
    logic [48:0] sum_wide;
    logic [15:0] number;
    logic        slot_ok;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;

    // A component of 5 or more alone exceeds the threshold; below that the squares are tiny.
    always_comb begin
        big_comp  = (item_reg.emissive_red > 16'd4) || (item_reg.emissive_green > 16'd4) ||
                    (item_reg.emissive_blue > 16'd4);
        small_sum = 6'(item_reg.emissive_red[2:0])   * 6'(item_reg.emissive_red[2:0])
                  + 6'(item_reg.emissive_green[2:0]) * 6'(item_reg.emissive_green[2:0])
                  + 6'(item_reg.emissive_blue[2:0])  * 6'(item_reg.emissive_blue[2:0]);
        emitter   = big_comp || (small_sum > EMIT_THRESHOLD);
        saturated = tri_cnt_reg >= TRI_W'(MAX_TRIANGLES);
        full      = emit_cnt_reg >= CNT_W'(MAX_LIGHTS);
        push_store = emitter && !saturated && !full;
        push_over  = emitter && (saturated || full);
        number     = 16'(tri_cnt_reg);
        weight     = lum_mode_reg ? {12'd0, prod_reg[47:12]} : {16'd0, item_reg.tri_area};
        sum_wide   = {1'b0, total_reg} + {1'b0, weight};
        tri_cnt_next  = saturated ? tri_cnt_reg : tri_cnt_reg + TRI_W'(1);
        emit_cnt_next = push_store ? emit_cnt_reg + CNT_W'(1) : emit_cnt_reg;
        if (push_store) begin
            total_next = sum_wide[48] ? TOTAL_MAX : sum_wide[47:0];
        end else begin
            total_next = total_reg;
        end
        slot_ok = (32'(item_reg.read_slot) < 32'(emit_cnt_reg)) &&
                  (32'(item_reg.read_slot) < MAX_LIGHTS);
        rd_addr = ADDR_W'(item_reg.read_slot);
        wr_addr = emit_cnt_reg[ADDR_W-1:0];
    end

    always_comb begin
        case (cmd.mul_sel)
            MUL_RED: begin
                mul_a = item_reg.emissive_red;
                mul_b = {16'd0, LUM_RED};
            end
            MUL_GREEN: begin
                mul_a = item_reg.emissive_green;
                mul_b = {16'd0, LUM_GREEN};
            end
            MUL_BLUE: begin
                mul_a = item_reg.emissive_blue;
                mul_b = {16'd0, LUM_BLUE};
            end
            MUL_AREA: begin
                mul_a = acc_reg[31:16];
                mul_b = item_reg.tri_area;
            end
            default: begin
                mul_a = 16'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    always_comb begin
        rem_shift = {rem_reg, (div_cnt_reg == 5'd16) ? rd_cum_reg[0] : 1'b0};
        rem_diff  = rem_shift - {1'b0, total_reg};
        q_bit     = rem_shift >= {1'b0, total_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lum_mode_reg <= 1'b0;
            tri_cnt_reg  <= '0;
            emit_cnt_reg <= '0;
            total_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                lum_mode_reg <= cfg_wr_data;
            end
            if (cmd.clear) begin
                tri_cnt_reg  <= '0;
                emit_cnt_reg <= '0;
                total_reg    <= '0;
            end else if (cmd.push_commit) begin
                tri_cnt_reg  <= tri_cnt_next;
                emit_cnt_reg <= emit_cnt_next;
                total_reg    <= total_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push_commit && push_store) begin
            tri_mem[wr_addr] <= number;
            cum_mem[wr_addr] <= total_next;
        end
        if (cmd.mem_rd) begin
            rd_tri_reg <= tri_mem[rd_addr];
            rd_cum_reg <= cum_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_item;
        end
        if (cmd.mul_en) begin
            prod_reg <= 48'(mul_a) * 48'(mul_b);
        end
        if (cmd.acc_load) begin
            acc_reg <= prod_reg[31:0];
        end else if (cmd.acc_add) begin
            acc_reg <= acc_reg + prod_reg[31:0];
        end
        if (cmd.res_clear) begin
            res_accepted_reg <= 1'b0;
            res_overflow_reg <= 1'b0;
            res_valid_reg    <= 1'b0;
            res_tri_reg      <= 16'd0;
            res_cdf_reg      <= 17'd0;
        end
        if (cmd.push_commit) begin
            res_accepted_reg <= push_store;
            res_overflow_reg <= push_over;
            res_tri_reg      <= push_store ? number : 16'd0;
        end
        if (cmd.mem_rd) begin
            res_valid_reg <= slot_ok;
        end
        if (cmd.div_init) begin
            res_tri_reg <= res_valid_reg ? rd_tri_reg : 16'd0;
            res_cdf_reg <= (res_valid_reg && (total_reg == 48'd0)) ? rd_cum_reg[16:0] : 17'd0;
            rem_reg     <= {1'b0, rd_cum_reg[47:1]};
            div_cnt_reg <= 5'd16;
        end
        if (cmd.div_step) begin
            rem_reg     <= q_bit ? rem_diff[47:0] : rem_shift[47:0];
            res_cdf_reg <= {res_cdf_reg[15:0], q_bit};
            div_cnt_reg <= div_cnt_reg - 5'd1;
        end
        if (cmd.load_out) begin
            out_reg.accepted          <= res_accepted_reg;
            out_reg.overflow          <= res_overflow_reg;
            out_reg.light_total_count <= 11'(emit_cnt_reg);
            out_reg.light_triangle    <= res_tri_reg;
            out_reg.cdf_value         <= res_cdf_reg;
            out_reg.total_weight      <= total_reg;
            out_reg.read_valid        <= res_valid_reg;
        end
    end

    assign status.action     = item_reg.action;
    assign status.lum_mode   = lum_mode_reg;
    assign status.div_needed = res_valid_reg && (total_reg != 48'd0);
    assign status.div_last   = div_cnt_reg == 5'd0;
    assign m_item            = out_reg;

endmodule

`default_nettype wire

/* rtl/elcdf_ctrl.sv */
// Controller: sequences each item through the datapath and owns both handshakes.
`timescale 1ns / 1ps
`default_nettype none

module elcdf_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    input  wire elcdf_pkg::status_t  status,
    output elcdf_pkg::cmd_t          cmd
);
    import elcdf_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DISP  = 4'd1;
    localparam logic [3:0] ST_MRED  = 4'd2;
    localparam logic [3:0] ST_MGRN  = 4'd3;
    localparam logic [3:0] ST_MBLU  = 4'd4;
    localparam logic [3:0] ST_MACC  = 4'd5;
    localparam logic [3:0] ST_MAREA = 4'd6;
    localparam logic [3:0] ST_PUSH  = 4'd7;
    localparam logic [3:0] ST_READ  = 4'd8;
    localparam logic [3:0] ST_DIVI  = 4'd9;
    localparam logic [3:0] ST_DIV   = 4'd10;
    localparam logic [3:0] ST_DONE  = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    always_comb begin
        out_free   = !m_valid_reg || m_ready;
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISP;
                end
            end
            ST_DISP: begin
                cmd.res_clear = 1'b1;
                case (status.action)
                    ACT_CLEAR: begin
                        cmd.clear  = 1'b1;
                        state_next = ST_DONE;
                    end
                    ACT_PUSH: begin
                        state_next = status.lum_mode ? ST_MRED : ST_PUSH;
                    end
                    ACT_READ: begin
                        state_next = ST_READ;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_MRED: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_RED;
                state_next  = ST_MGRN;
            end
            ST_MGRN: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_GREEN;
                cmd.acc_load = 1'b1;
                state_next   = ST_MBLU;
            end
            ST_MBLU: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_BLUE;
                cmd.acc_add = 1'b1;
                state_next  = ST_MACC;
            end
            ST_MACC: begin
                cmd.acc_add = 1'b1;
                state_next  = ST_MAREA;
            end
            ST_MAREA: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_AREA;
                state_next  = ST_PUSH;
            end
            ST_PUSH: begin
                cmd.push_commit = 1'b1;
                state_next      = ST_DONE;
            end
            ST_READ: begin
                cmd.mem_rd = 1'b1;
                state_next = ST_DIVI;
            end
            ST_DIVI: begin
                cmd.div_init = 1'b1;
                state_next   = status.div_needed ? ST_DIV : ST_DONE;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

/* tb/emitter_light_cdf_builder_top_tb.sv */
// Self-checking testbench for the emitter light CDF builder top level.
`timescale 1ns / 1ps

module emitter_light_cdf_builder_top_tb;
    import elcdf_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int SCENE_PUSHES = MAX_LIGHTS_DEFAULT + 200;

    logic      aclk;
    logic      aresetn;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;
    logic      cfg_wr_en = 1'b0;
    logic      cfg_wr_data = 1'b0;

    in_item_t  scene_items[$];
    out_item_t due_results[$];

    bit              lum_mode;
    int              tri_count;
    int              light_count;
    longint unsigned weight_sum;
    logic [15:0]     slot_tri[MAX_LIGHTS_DEFAULT];
    longint unsigned slot_cum[MAX_LIGHTS_DEFAULT];

    bit quiet;
    bit hold_off;
    int send_gap;
    int take_stall;
    int items_sent;
    int results_seen;
    int failures;
    int lights_stored;
    int lights_dropped;
    int slot_reads;
    int mode_writes;

    emitter_light_cdf_builder_top DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        aresetn = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
    end

    function automatic out_item_t light_table_step(in_item_t it);
        out_item_t       res;
        longint unsigned r, g, b, area, energy, weight, cum;
        int              number;
        bit              saturated;
        res = '0;
        r = it.emissive_red;
        g = it.emissive_green;
        b = it.emissive_blue;
        area = it.tri_area;
        case (it.action)
            ACT_CLEAR: begin
                tri_count = 0;
                light_count = 0;
                weight_sum = 0;
            end
            ACT_PUSH: begin
                energy = r * r + g * g + b * b;
                saturated = tri_count >= MAX_TRIANGLES_DEFAULT;
                number = tri_count;
                if (!saturated) tri_count++;
                if (energy > EMIT_THRESHOLD) begin
                    if (saturated || light_count >= MAX_LIGHTS_DEFAULT) begin
                        res.overflow = 1'b1;
                        lights_dropped++;
                    end else begin
                        if (lum_mode)
                            weight = (((LUM_RED * r + LUM_GREEN * g + LUM_BLUE * b) >> 16)
                                      * area) >> 12;
                        else
                            weight = area;
                        if (weight > TOTAL_MAX - weight_sum) weight_sum = TOTAL_MAX;
                        else weight_sum = weight_sum + weight;
                        slot_tri[light_count] = number[15:0];
                        slot_cum[light_count] = weight_sum;
                        light_count++;
                        res.accepted = 1'b1;
                        res.light_triangle = number[15:0];
                        lights_stored++;
                    end
                end
            end
            ACT_READ: begin
                if (it.read_slot < light_count) begin
                    cum = slot_cum[it.read_slot];
                    res.read_valid = 1'b1;
                    res.light_triangle = slot_tri[it.read_slot];
                    res.cdf_value = (weight_sum == 0) ? cum : (cum << 16) / weight_sum;
                    slot_reads++;
                end
            end
            default: ;
        endcase
        res.light_total_count = light_count[10:0];
        res.total_weight = weight_sum[47:0];
        return res;
    endfunction

    function automatic in_item_t make_item(logic [1:0] action, logic [15:0] r, logic [15:0] g,
                                           logic [15:0] b, logic [31:0] area,
                                           logic [9:0] slot);
        in_item_t it;
        it.action = action;
        it.emissive_red = r;
        it.emissive_green = g;
        it.emissive_blue = b;
        it.tri_area = area;
        it.read_slot = slot;
        return it;
    endfunction

    function automatic void add_item(in_item_t it);
        scene_items.insert(scene_items.size(), it);
    endfunction

    function automatic logic [15:0] random_channel();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 15));
            2: return 16'hFFFF - 16'($urandom_range(0, 255));
            default: return 16'($urandom >> $urandom_range(16, 31));
        endcase
    endfunction

    function automatic logic [31:0] random_area();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        int       pick;
        it = make_item(ACT_PUSH, random_channel(), random_channel(), random_channel(),
                       random_area(), 10'($urandom_range(0, 1) ? $urandom_range(0, 1023)
                                                                : $urandom_range(0, 31)));
        pick = $urandom_range(0, 199);
        if (pick == 0) begin
            it.action = ACT_CLEAR;
        end else if (pick < 6) begin
            it.action = ACT_UNUSED;
        end else if (pick < 76) begin
            it.action = ACT_READ;
        end else if (pick < 96) begin
            it.emissive_red = 16'($urandom_range(0, 2));
            it.emissive_green = 16'($urandom_range(0, 2));
            it.emissive_blue = 16'($urandom_range(0, 2));
        end
        return it;
    endfunction

    task automatic wait_drained();
        @(negedge aclk);
        while (scene_items.size() != 0 || s_valid || due_results.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_mode(bit value);
        wait_drained();
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        lum_mode = value;
        mode_writes++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                due_results.insert(due_results.size(), light_table_step(s_item));
                items_sent++;
            end
            if (!(s_valid && !s_ready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 4);
                    s_valid <= 1'b0;
                end else if (scene_items.size() != 0) begin
                    s_item <= scene_items.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    $error("result transfer with no expected result waiting");
                    failures++;
                end else begin
                    want = due_results.pop_front();
                    if (m_item.accepted !== want.accepted) begin
                        $error("accepted: expected %0d, got %0d", want.accepted,
                               m_item.accepted);
                        failures++;
                    end
                    if (m_item.overflow !== want.overflow) begin
                        $error("overflow: expected %0d, got %0d", want.overflow,
                               m_item.overflow);
                        failures++;
                    end
                    if (m_item.light_total_count !== want.light_total_count) begin
                        $error("light_total_count: expected %0d, got %0d",
                               want.light_total_count, m_item.light_total_count);
                        failures++;
                    end
                    if (m_item.light_triangle !== want.light_triangle) begin
                        $error("light_triangle: expected %0d, got %0d", want.light_triangle,
                               m_item.light_triangle);
                        failures++;
                    end
                    if (m_item.cdf_value !== want.cdf_value) begin
                        $error("cdf_value: expected %0d, got %0d", want.cdf_value,
                               m_item.cdf_value);
                        failures++;
                    end
                    if (m_item.total_weight !== want.total_weight) begin
                        $error("total_weight: expected %0d, got %0d", want.total_weight,
                               m_item.total_weight);
                        failures++;
                    end
                    if (m_item.read_valid !== want.read_valid) begin
                        $error("read_valid: expected %0d, got %0d", want.read_valid,
                               m_item.read_valid);
                        failures++;
                    end
                end
            end
            if (hold_off) begin
                m_ready <= 1'b0;
            end else if (take_stall > 0) begin
                take_stall--;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                take_stall = $urandom_range(0, 4);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // The long hold-off makes the block stall its input while transfers keep being offered.
    initial begin
        hold_off = 1'b0;
        wait (results_seen >= 200);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (400) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin
        #100_000_000;
        $display("emitter_light_cdf_builder_top test failed");
        $finish;
    end

    initial begin
        int pushes;
        wait (aresetn === 1'b1);
        write_mode(1'b1);

        add_item(make_item(ACT_READ, 16'd0, 16'd0, 16'd0, 32'd0, 10'd0));
        add_item(make_item(ACT_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 10'h3FF));
        add_item(make_item(ACT_PUSH, 16'd0, 16'd0, 16'd0, 32'hFFFF_FFFF, 10'd0));
        add_item(make_item(ACT_PUSH, 16'd4, 16'd0, 16'd0, 32'hFFFF_FFFF, 10'd0));
        add_item(make_item(ACT_PUSH, 16'd4, 16'd1, 16'd0, 32'd0, 10'd0));
        add_item(make_item(ACT_READ, 16'd0, 16'd0, 16'd0, 32'd0, 10'd0));
        add_item(make_item(ACT_PUSH, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 10'd0));
        add_item(make_item(ACT_PUSH, 16'd0, 16'd0, 16'hFFFF, 32'd1, 10'd0));
        add_item(make_item(ACT_PUSH, 16'hFFFF, 16'd0, 16'd0, 32'h0001_0000, 10'd0));
        add_item(make_item(ACT_PUSH, 16'd0, 16'hFFFF, 16'd0, 32'h8000_0000, 10'd0));
        for (int s = 0; s < 6; s++)
            add_item(make_item(ACT_READ, 16'd0, 16'd0, 16'd0, 32'd0, 10'(s)));
        add_item(make_item(ACT_READ, 16'd0, 16'd0, 16'd0, 32'd0, 10'h3FF));
        add_item(make_item(ACT_CLEAR, 16'd0, 16'd0, 16'd0, 32'd0, 10'd0));
        add_item(make_item(ACT_READ, 16'd0, 16'd0, 16'd0, 32'd0, 10'd0));

        write_mode(1'b0);
        repeat (150) add_item(random_item());

        // Luminance weighting on top of a table built with area weights.
        write_mode(1'b1);
        repeat (120) add_item(random_item());

        // A long scene of mostly emitting triangles fills the table and then overflows it.
        write_mode(1'b0);
        add_item(make_item(ACT_CLEAR, 16'd0, 16'd0, 16'd0, 32'd0, 10'd0));
        pushes = 0;
        while (pushes < SCENE_PUSHES) begin
            if ($urandom_range(0, 299) == 0) begin
                add_item(make_item(ACT_READ, 16'd0, 16'd0, 16'd0, 32'd0,
                                   10'($urandom_range(0, 1023))));
            end else if ($urandom_range(0, 24) == 0) begin
                add_item(make_item(ACT_PUSH, 16'($urandom_range(0, 2)),
                                   16'($urandom_range(0, 2)),
                                   16'($urandom_range(0, 2)), random_area(), 10'd0));
                pushes++;
            end else if ($urandom_range(0, 19) == 0) begin
                add_item(make_item(ACT_PUSH, 16'd4, 16'd0, 16'd0, random_area(), 10'd0));
                pushes++;
            end else begin
                add_item(make_item(ACT_PUSH, random_channel(), random_channel(),
                                   random_channel(), random_area(), 10'd0));
                pushes++;
            end
        end
        repeat (40) add_item(make_item(ACT_READ, 16'd0, 16'd0, 16'd0, 32'd0,
                                       10'($urandom_range(0, 1023))));

        write_mode(1'b1);
        quiet = 1'b1;
        add_item(make_item(ACT_CLEAR, 16'd0, 16'd0, 16'd0, 32'd0, 10'd0));
        repeat (60) add_item(random_item());

        wait_drained();
        repeat (40) @(posedge aclk);
        if (due_results.size() != 0) begin
            $error("%0d expected results never arrived", due_results.size());
            failures++;
        end

        $display("Run covered %0d input transfers and %0d result transfers over %0d mode writes.",
                 items_sent, results_seen, mode_writes);
        $display("Lights stored %0d, dropped on overflow %0d, valid slot reads %0d.",
                 lights_stored, lights_dropped, slot_reads);
        if (failures == 0) begin
            $display("emitter_light_cdf_builder_top test passed");
        end else begin
            $display("emitter_light_cdf_builder_top test failed");
        end
        $finish;
    end

endmodule
